@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, ignored while reset is high.
`define VOR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked property, also during reset.
`define VOR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define VOR_ASSERT(lbl, clk, rst, prop)
`define VOR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ src/vor_pkg.sv @@
package vor_pkg;

  // Grid size default
  localparam int DEF_MAX_DIM = 64;

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_EMIT   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_code_t;

  // Cell kinds
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_LEAF  = 2'd1;
  localparam logic [1:0] KIND_BARK  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE = 3'd3;
  localparam logic [2:0] REG_SIZE_X    = 3'd4;
  localparam logic [2:0] REG_SIZE_Y    = 3'd5;
  localparam logic [2:0] REG_SIZE_Z    = 3'd6;

  // Register reset values
  localparam logic [15:0] CELL_SIZE_RST = 16'd100;
  localparam logic [6:0]  SIZE_RST      = 7'd64;

  // Hash constants
  localparam logic [31:0] HASH_MX = 32'd73856093;
  localparam logic [31:0] HASH_MY = 32'd19349663;
  localparam logic [31:0] HASH_MZ = 32'd83492791;
  localparam logic [31:0] HASH_M1 = 32'h7feb352d;
  localparam logic [31:0] HASH_M2 = 32'h846ca68b;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_START,
    ST_INS_DIV,
    ST_INS_RD,
    ST_INS_WR,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_COUNT,
    ST_DRAIN,
    ST_OUT
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic clr_start;
    logic clr_step;
    logic div_start;
    logic idx_store;
    logic ins_rd;
    logic ins_wr;
    logic scan_step;
    logic mark_done;
    logic scan_hit;
    logic cnt_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic axis_neg;
    logic div_done;
    logic q_over;
    logic axis_last;
    logic scan_end;
    logic scan_inrange;
    logic cell_occ;
    logic cnt_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ src/vor_ram.sv @@
module vor_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/vor_div.sv @@
module vor_div import vor_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        run;
  logic [4:0]  step;
  logic [15:0] rem;
  logic [31:0] dvd;
  logic [15:0] dsr;
  logic [16:0] rem_s;
  logic        qbit;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_s = {rem, dvd[31]};
    qbit  = rem_s >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= run && (step == 5'd31);
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (run) begin
      rem <= qbit ? 16'(rem_s - {1'b0, dsr}) : rem_s[15:0];
      dvd <= {dvd[30:0], qbit};
    end
  end

  assign quotient = dvd;

endmodule

@@ src/vor_ctrl.sv @@
module vor_ctrl import vor_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  cmd_code_t in_cmd,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output dp_cmd_t   cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_INSERT: state_next = ST_INS_START;
            CMD_EMIT:   state_next = ST_SCAN;
            CMD_CLEAR:  state_next = ST_CLEAR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_INS_START: begin
        state_next = sts.axis_neg ? ST_IDLE : ST_INS_DIV;
      end
      ST_INS_DIV: begin
        if (sts.div_done) begin
          if (sts.q_over) state_next = ST_IDLE;
          else if (sts.axis_last) state_next = ST_INS_RD;
          else state_next = ST_INS_START;
        end
      end
      ST_INS_RD: state_next = ST_INS_WR;
      ST_INS_WR: state_next = ST_IDLE;
      ST_SCAN: begin
        if (sts.scan_end) state_next = ST_OUT;
        else if (sts.scan_inrange) state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_next = sts.cell_occ ? ST_COUNT : ST_SCAN;
      end
      ST_COUNT: begin
        if (sts.cnt_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        cmd.clr_start = in_valid && (in_cmd == CMD_CLEAR);
      end
      ST_INS_START: cmd.div_start = !sts.axis_neg;
      ST_INS_DIV:   cmd.idx_store = sts.div_done && !sts.q_over;
      ST_INS_RD:    cmd.ins_rd = 1'b1;
      ST_INS_WR:    cmd.ins_wr = 1'b1;
      ST_SCAN: begin
        cmd.mark_done = sts.scan_end;
        cmd.scan_step = !sts.scan_end;
      end
      ST_SCAN_CHK: cmd.scan_hit = sts.cell_occ;
      ST_COUNT:    cmd.cnt_step = 1'b1;
      ST_OUT:      cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ src/vor_dp.sv @@
`include "assert_macros.svh"

module vor_dp import vor_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic [15:0]        cell_size,
  input  logic [6:0]         size_x,
  input  logic [6:0]         size_y,
  input  logic [6:0]         size_z,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic               in_bark,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         cell_x,
  output logic [5:0]         cell_y,
  output logic [5:0]         cell_z,
  output logic [1:0]         kind,
  output logic [12:0]        occlusion_key,
  output logic               scan_done
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int NW = CW + 1;
  localparam int AW = 3 * CW;
  localparam int PW = AW + 1;
  localparam logic [2:0] OFF_LAST = 3'd4;
  localparam logic [6:0] CNT_MAX = 7'd125;
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  logic signed [31:0] pt_x, pt_y, pt_z;
  logic               bark;
  logic [1:0]         axis;
  logic [CW-1:0]      idx_x, idx_y, idx_z;
  logic [AW-1:0]      clr_cnt;
  logic [PW-1:0]      pos;
  logic [CW-1:0]      cur_x, cur_y, cur_z;
  logic [1:0]         kind_r;
  logic               done_flag;
  logic [2:0]         ox, oy, oz;
  logic               nb_pend;
  logic [6:0]         cnt;
  logic [31:0]        h0, h1, h2, hv;

  logic [NW-1:0]      nx, ny, nz, sel_n;
  logic signed [31:0] sel_p, sel_o;
  logic [32:0]        diff;
  logic [15:0]        cs_eff;
  logic               div_done;
  logic [31:0]        div_q;
  logic [NW-1:0]      sx, sy, sz;
  logic               nb_in;
  logic [AW-1:0]      nb_addr, ins_addr;
  logic               scan_inrange;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [1:0]         ram_wdata, ram_rdata;

  // Effective grid sizes and cell size
  always_comb begin
    nx = (9'(size_x) > 9'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(size_x);
    ny = (9'(size_y) > 9'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(size_y);
    nz = (9'(size_z) > 9'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(size_z);
    cs_eff = (cell_size == '0) ? 16'd1 : cell_size;
  end

  // Axis select for quantising
  always_comb begin
    case (axis)
      AX_X:    begin sel_p = pt_x; sel_o = origin_x; sel_n = nx; end
      AX_Y:    begin sel_p = pt_y; sel_o = origin_y; sel_n = ny; end
      default: begin sel_p = pt_z; sel_o = origin_z; sel_n = nz; end
    endcase
    diff = {sel_p[31], sel_p} - {sel_o[31], sel_o};
  end

  vor_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (diff[31:0]),
    .divisor  (cs_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // Input word and quantised indexes
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pt_x <= in_x;
      pt_y <= in_y;
      pt_z <= in_z;
      bark <= in_bark;
      axis <= AX_X;
    end else if (cmd.idx_store) begin
      axis <= axis + 2'd1;
      case (axis)
        AX_X:    idx_x <= div_q[CW-1:0];
        AX_Y:    idx_y <= div_q[CW-1:0];
        default: idx_z <= div_q[CW-1:0];
      endcase
    end
  end

  assign ins_addr = {idx_z, idx_y, idx_x};

  // Clear sweep and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pos     <= '0;
    end else begin
      if (cmd.clr_start) begin
        clr_cnt <= '0;
        pos     <= '0;
      end else begin
        if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
        if (cmd.scan_step) pos <= pos + PW'(1);
      end
    end
  end

  assign scan_inrange = ({1'b0, pos[CW-1:0]} < nx) &&
                        ({1'b0, pos[2*CW-1:CW]} < ny) &&
                        ({1'b0, pos[3*CW-1:2*CW]} < nz);

  // Current cell, kind and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      done_flag <= 1'b0;
    end else if (cmd.mark_done) begin
      done_flag <= 1'b1;
    end else if (cmd.scan_hit) begin
      done_flag <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && scan_inrange) begin
      cur_x <= pos[CW-1:0];
      cur_y <= pos[2*CW-1:CW];
      cur_z <= pos[3*CW-1:2*CW];
    end
    if (cmd.scan_hit) kind_r <= ram_rdata;
  end

  // Neighbourhood walk
  always_comb begin
    sx = {1'b0, cur_x} + NW'(ox);
    sy = {1'b0, cur_y} + NW'(oy);
    sz = {1'b0, cur_z} + NW'(oz);
    nb_in = (sx >= NW'(2)) && (NW'(sx - NW'(2)) < nx) &&
            (sy >= NW'(2)) && (NW'(sy - NW'(2)) < ny) &&
            (sz >= NW'(2)) && (NW'(sz - NW'(2)) < nz);
    nb_addr = {CW'(sz - NW'(2)), CW'(sy - NW'(2)), CW'(sx - NW'(2))};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_pend <= 1'b0;
    end else begin
      nb_pend <= cmd.cnt_step && nb_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_hit) begin
      ox  <= '0;
      oy  <= '0;
      oz  <= '0;
      cnt <= '0;
    end else begin
      if (cmd.cnt_step) begin
        if (ox == OFF_LAST) begin
          ox <= '0;
          if (oy == OFF_LAST) begin
            oy <= '0;
            oz <= oz + 3'd1;
          end else begin
            oy <= oy + 3'd1;
          end
        end else begin
          ox <= ox + 3'd1;
        end
      end
      if (nb_pend && (ram_rdata != KIND_EMPTY)) cnt <= cnt + 7'd1;
    end
  end

  // Hash of the current cell, three registered multiply stages
  always_ff @(posedge clk) begin
    h0 <= (32'(cur_x) * HASH_MX) ^ (32'(cur_y) * HASH_MY) ^ (32'(cur_z) * HASH_MZ);
    h1 <= (h0 ^ (h0 >> 16)) * HASH_M1;
    h2 <= (h1 ^ (h1 >> 15)) * HASH_M2;
  end

  assign hv = h2 ^ (h2 >> 16);

  // Occupancy memory port muxing
  always_comb begin
    ram_re    = cmd.ins_rd || (cmd.scan_step && scan_inrange) || (cmd.cnt_step && nb_in);
    ram_raddr = ins_addr;
    if (cmd.cnt_step) ram_raddr = nb_addr;
    else if (cmd.scan_step) ram_raddr = pos[AW-1:0];
    ram_we    = cmd.clr_step || (cmd.ins_wr && (bark || ram_rdata == KIND_EMPTY));
    ram_waddr = cmd.clr_step ? clr_cnt : ins_addr;
    ram_wdata = cmd.clr_step ? KIND_EMPTY : (bark ? KIND_BARK : KIND_LEAF);
  end

  vor_ram #(
    .WIDTH (2),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (done_flag) begin
        cell_x        <= '0;
        cell_y        <= '0;
        cell_z        <= '0;
        kind          <= KIND_EMPTY;
        occlusion_key <= '0;
        scan_done     <= 1'b1;
      end else begin
        cell_x        <= 6'(cur_x);
        cell_y        <= 6'(cur_y);
        cell_z        <= 6'(cur_z);
        kind          <= kind_r;
        occlusion_key <= {cnt, hv[5:0]};
        scan_done     <= 1'b0;
      end
    end
  end

  // Status
  always_comb begin
    sts.clr_last     = (clr_cnt == '1);
    sts.axis_neg     = diff[32];
    sts.div_done     = div_done;
    sts.q_over       = div_q >= 32'(sel_n);
    sts.axis_last    = (axis == AX_Z);
    sts.scan_end     = pos[PW-1];
    sts.scan_inrange = scan_inrange;
    sts.cell_occ     = (ram_rdata != KIND_EMPTY);
    sts.cnt_last     = (ox == OFF_LAST) && (oy == OFF_LAST) && (oz == OFF_LAST);
    sts.out_free     = !out_valid || out_ready;
  end

  `VOR_ASSERT(a_cnt_max, clk, rst, cnt <= CNT_MAX)
  `VOR_ASSERT(a_nb_pend, clk, rst, nb_pend |-> $past(cmd.cnt_step))
  `VOR_ASSERT(a_pos_end, clk, rst, pos[PW-1] |-> (pos[AW-1:0] == '0))
  `VOR_ASSERT(a_one_writer, clk, rst, !(cmd.clr_step && cmd.ins_wr))

endmodule

@@ src/voxel_occupancy_occlusion_rank.sv @@
// Voxel occupancy grid with an occlusion-rank scan.
// Input stream (s_*): one word per command. s_tuser holds command and
// is_bark; s_tdata holds point_x, point_y, point_z. Insert quantises the
// point into the grid, emit returns the next occupied cell, clear empties it.
// Output stream (m_*): one word per emit. m_tdata holds the cell indexes and
// occlusion_key; m_tuser holds kind and scan_done.
// An insert passes each of the three axes through the shared one-bit-per-cycle
// divider, then does a read-modify-write of the cell. An emit steps over each
// skipped cell outside the sizes in use and probes each cell in use until one
// is occupied, then counts its 5x5x5 neighbours, reading the memory for each
// one inside the grid, and loads the result register. A clear writes all
// MAX_DIM-rounded-up-to-a-power-of-two cubed memory entries (262144 at
// the default), one memory entry per cycle.
// Reset runs the same clearing pass; s_tready stays low until it is done.
// APB writes are taken at any time. A stalled receiver holds the result in
// the output register; the next command is still accepted, and a following
// emit waits only when it has its own result to load.
module voxel_occupancy_occlusion_rank import vor_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // point_x, point_y, point_z
  input  logic [2:0]  s_tuser,   // command[1:0], is_bark
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_x, cell_y, cell_z, occlusion_key, zero pad
  output logic [2:0]  m_tuser,   // kind[1:0], scan_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [15:0]        cell_size;
  logic [6:0]         size_x, size_y, size_z;
  logic               cfg_we;
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [5:0]         cell_x, cell_y, cell_z;
  logic [1:0]         kind;
  logic [12:0]        occlusion_key;
  logic               scan_done;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      cell_size <= CELL_SIZE_RST;
      size_x    <= SIZE_RST;
      size_y    <= SIZE_RST;
      size_z    <= SIZE_RST;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_ORIGIN_X:  origin_x  <= pwdata;
        REG_ORIGIN_Y:  origin_y  <= pwdata;
        REG_ORIGIN_Z:  origin_z  <= pwdata;
        REG_CELL_SIZE: cell_size <= pwdata[15:0];
        REG_SIZE_X:    size_x    <= pwdata[6:0];
        REG_SIZE_Y:    size_y    <= pwdata[6:0];
        REG_SIZE_Z:    size_z    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (paddr[4:2])
      REG_ORIGIN_X:  prdata = origin_x;
      REG_ORIGIN_Y:  prdata = origin_y;
      REG_ORIGIN_Z:  prdata = origin_z;
      REG_CELL_SIZE: prdata = 32'(cell_size);
      REG_SIZE_X:    prdata = 32'(size_x);
      REG_SIZE_Y:    prdata = 32'(size_y);
      REG_SIZE_Z:    prdata = 32'(size_z);
      default:       prdata = '0;
    endcase
  end

  vor_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (cmd_code_t'(s_tuser[1:0])),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vor_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .origin_z      (origin_z),
    .cell_size     (cell_size),
    .size_x        (size_x),
    .size_y        (size_y),
    .size_z        (size_z),
    .in_x          (s_tdata[31:0]),
    .in_y          (s_tdata[63:32]),
    .in_z          (s_tdata[95:64]),
    .in_bark       (s_tuser[2]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .cell_z        (cell_z),
    .kind          (kind),
    .occlusion_key (occlusion_key),
    .scan_done     (scan_done)
  );

  assign m_tdata = {1'b0, occlusion_key, cell_z, cell_y, cell_x};
  assign m_tuser = {scan_done, kind};

endmodule
